// ===== src/ll1p_pkg.sv =====
// ---------------------------------------------------------------------------
// ll1p_pkg: shared types and constants of the LL(1) predictive parser
// Item structs, function codes, status codes and default sizes.
// ---------------------------------------------------------------------------
package ll1p_pkg;

    localparam int DefNumTerminals    = 32;
    localparam int DefNumNonterminals = 32;
    localparam int DefMaxProdLength   = 8;
    localparam int DefStackDepth      = 64;

    localparam logic [1:0] FUNC_LOAD_SYM = 2'd0;
    localparam logic [1:0] FUNC_LOAD_LEN = 2'd1;
    localparam logic [1:0] FUNC_BEGIN    = 2'd2;
    localparam logic [1:0] FUNC_TOKEN    = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CONSUMED   = 3'd1;
    localparam logic [2:0] ST_ACCEPTED   = 3'd2;
    localparam logic [2:0] ST_NO_ENTRY   = 3'd3;
    localparam logic [2:0] ST_MISMATCH   = 3'd4;
    localparam logic [2:0] ST_INVALID    = 3'd5;
    localparam logic [2:0] ST_OVERFLOW   = 3'd6;
    localparam logic [2:0] ST_NOT_PARSE  = 3'd7;

    localparam logic [1:0] CFG_TERM_COUNT = 2'd0;
    localparam logic [1:0] CFG_NT_COUNT   = 2'd1;
    localparam logic [1:0] CFG_EPSILON    = 2'd2;

    localparam logic [6:0] END_MARK = 7'd64;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] nonterminal_index;
        logic [4:0] terminal_index;
        logic [2:0] slot;
        logic [5:0] symbol_code;
        logic [3:0] entry_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] expected_symbol;
        logic [6:0] stack_level;
    } out_item_t;

endpackage

// ===== src/ll1p_table.sv =====
// ---------------------------------------------------------------------------
// ll1p_table: parse table storage
// Entry lengths and production symbols, one write and one read port each, registered reads.
// Lengths are cleared by a sweep after reset.
// ---------------------------------------------------------------------------
module ll1p_table
    import ll1p_pkg::*;
#(
    parameter int NT = DefNumTerminals,
    parameter int NN = DefNumNonterminals,
    parameter int ML = DefMaxProdLength,
    localparam int EW = $clog2(NT * NN),
    localparam int SW = $clog2(ML) > 0 ? $clog2(ML) : 1,
    localparam int LW = $clog2(ML + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          len_we,
    input  logic [EW-1:0] len_waddr,
    input  logic [LW-1:0] len_wdata,
    input  logic [EW-1:0] len_raddr,
    output logic [LW-1:0] len_rdata,
    input  logic          sym_we,
    input  logic [EW+SW-1:0] sym_waddr,
    input  logic [5:0]    sym_wdata,
    input  logic [EW+SW-1:0] sym_raddr,
    output logic [5:0]    sym_rdata,
    output logic          clear_busy
);

    localparam int ED = NT * NN;

    logic [LW-1:0] len_mem [ED];
    logic [5:0]    sym_mem [ED * ML];
    logic [EW:0]   clr_reg;

    // sweep the length store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clear_busy)
            clr_reg <= clr_reg + 1'b1;
    end

    assign clear_busy = (clr_reg < (EW+1)'(ED));

    // length store
    always_ff @(posedge clk)
    begin
        if (clear_busy)
            len_mem[clr_reg[EW-1:0]] <= '0;
        else if (len_we)
            len_mem[len_waddr] <= len_wdata;
        len_rdata <= len_mem[len_raddr];
    end

    // symbol store
    always_ff @(posedge clk)
    begin
        if (sym_we)
            sym_mem[sym_waddr] <= sym_wdata;
        sym_rdata <= sym_mem[sym_raddr];
    end

endmodule

// ===== src/ll1_predictive_parser.sv =====
// ---------------------------------------------------------------------------
// ll1_predictive_parser: table-driven LL(1) parser over token indices
// Load items fill the table, a begin item starts a parse and each token
// item runs expansions until the token is consumed or the parse ends.
//
// Channels: in_* and out_* use valid/ready; one result item per input item.
// cfg_we/cfg_index/cfg_data write the three count/epsilon registers.
// Flow: a load item goes straight to the output register. A begin item
// writes the end marker and then the start nonterminal on the stack. A
// token item reads the stack top, pops epsilons and a matching terminal,
// and for a nonterminal reads the entry length and then pushes the
// production; an error or acceptance ends the parse with a result.
// The stack and table memories have one registered read port each.
// After reset the block clears the entry-length store, one entry per cycle,
// before in_ready rises.
// A new item is taken only once the previous result has been handed over;
// a stalled receiver holds the result in the output register.
// ---------------------------------------------------------------------------
module ll1_predictive_parser
    import ll1p_pkg::*;
#(
    parameter int NUM_TERMINALS         = DefNumTerminals,
    parameter int NUM_NONTERMINALS      = DefNumNonterminals,
    parameter int MAX_PRODUCTION_LENGTH = DefMaxProdLength,
    parameter int STACK_DEPTH           = DefStackDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    localparam int EW  = $clog2(NUM_TERMINALS * NUM_NONTERMINALS);
    localparam int SW  = $clog2(MAX_PRODUCTION_LENGTH) > 0 ? $clog2(MAX_PRODUCTION_LENGTH) : 1;
    localparam int LW  = $clog2(MAX_PRODUCTION_LENGTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int CW  = $clog2(STACK_DEPTH * (NUM_NONTERMINALS + 2) + 1);
    localparam int STEP_LIMIT = STACK_DEPTH * (NUM_NONTERMINALS + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PARSING = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [5:0]  tcount_reg, ntcount_reg;
    logic [4:0]  eps_reg;
    logic [4:0]  tok_reg, tok_next;
    logic [EW-1:0] idx_reg, idx_next;
    logic [LW-1:0] k_reg, k_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    // stack memory, registered read
    logic [6:0]  stack_mem [STACK_DEPTH];
    logic [6:0]  top_rdata;
    logic        st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [6:0]  st_wdata;
    logic        top_is_end;
    logic [6:0]  top_sym;

    // table ports
    logic          len_we, sym_we, clear_busy;
    logic [EW-1:0] len_waddr, len_raddr;
    logic [LW-1:0] len_wdata, len_rdata;
    logic [EW+SW-1:0] sym_waddr, sym_raddr;
    logic [5:0]    sym_rdata;
    logic          load_ok;

    ll1p_table #(
        .NT(NUM_TERMINALS), .NN(NUM_NONTERMINALS), .ML(MAX_PRODUCTION_LENGTH)
    ) u_table (
        .clk(clk), .rst_n(rst_n),
        .len_we(len_we), .len_waddr(len_waddr), .len_wdata(len_wdata),
        .len_raddr(len_raddr), .len_rdata(len_rdata),
        .sym_we(sym_we), .sym_waddr(sym_waddr), .sym_wdata(in_data.symbol_code),
        .sym_raddr(sym_raddr), .sym_rdata(sym_rdata),
        .clear_busy(clear_busy)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg && !clear_busy;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // load decode
    assign load_ok = (32'(in_data.nonterminal_index) < NUM_NONTERMINALS)
                  && (32'(in_data.terminal_index) < NUM_TERMINALS);
    assign len_waddr = EW'(32'(in_data.nonterminal_index) * NUM_TERMINALS
                           + 32'(in_data.terminal_index));
    assign len_wdata = (32'(in_data.entry_length) > MAX_PRODUCTION_LENGTH)
                     ? LW'(MAX_PRODUCTION_LENGTH) : LW'(in_data.entry_length);
    assign sym_waddr = (EW+SW)'(32'(len_waddr) * MAX_PRODUCTION_LENGTH
                                + 32'(in_data.slot));
    assign len_we = in_valid && in_ready && (in_data.func == FUNC_LOAD_LEN) && load_ok;
    assign sym_we = in_valid && in_ready && (in_data.func == FUNC_LOAD_SYM) && load_ok
                 && (32'(in_data.slot) < MAX_PRODUCTION_LENGTH);
    assign len_raddr = idx_next;
    assign sym_raddr = (EW+SW)'(32'(idx_reg) * MAX_PRODUCTION_LENGTH
                                + 32'(k_next) - 1);

    // the end marker sits at the bottom of the stack once a parse has begun
    assign top_is_end = (sp_reg == '0) || (top_rdata == END_MARK);
    assign top_sym    = top_is_end ? END_MARK : top_rdata;
    assign st_raddr   = AW'(sp_next - 1'b1);

    // stack memory; pass a same-cycle write through to the read data
    always_ff @(posedge clk)
    begin
        if (st_we)
            stack_mem[st_waddr] <= st_wdata;
        if (st_we && st_waddr == st_raddr)
            top_rdata <= st_wdata;
        else
            top_rdata <= stack_mem[st_raddr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcount_reg  <= 6'd32;
            ntcount_reg <= 6'd32;
            eps_reg     <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TERM_COUNT: tcount_reg  <= cfg_data;
                CFG_NT_COUNT:   ntcount_reg <= cfg_data;
                CFG_EPSILON:    eps_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        logic [5:0] nt;
        logic [2:0] st;
        state_next     = state_reg;
        phase_next     = phase_reg;
        sp_next        = sp_reg;
        steps_next     = steps_reg;
        tok_next       = tok_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        st_we          = 1'b0;
        st_waddr       = AW'(sp_reg);
        st_wdata       = top_rdata;
        nt             = top_rdata[5:0] - 6'd32;
        st             = ST_OK;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    out_next = '0;
                    case (in_data.func)
                        FUNC_BEGIN:
                        begin
                            st_we      = 1'b1;
                            st_waddr   = '0;
                            st_wdata   = END_MARK;
                            sp_next    = PW'(1);
                            phase_next = PH_PARSING;
                            state_next = S_PUSH;
                            k_next     = '0;
                        end
                        FUNC_TOKEN:
                        begin
                            if (phase_reg != PH_PARSING)
                            begin
                                out_next.status      = ST_NOT_PARSE;
                                out_next.stack_level = 7'(sp_reg);
                                state_next           = S_OUT;
                            end
                            else
                            begin
                                tok_next   = in_data.terminal_index;
                                steps_next = '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            out_next.stack_level = 7'(sp_reg);
                            state_next           = S_OUT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // stack top read issued last cycle; evaluate next
                state_next = S_EVAL;
                if (32'(tok_reg) >= 32'(tcount_reg) || 32'(tok_reg) >= NUM_TERMINALS)
                begin
                    st = ST_INVALID;
                end
                else
                    st = ST_OK;
                if (st != ST_OK)
                begin
                    out_next.status          = st;
                    out_next.expected_symbol = top_sym;
                    out_next.stack_level     = 7'(sp_reg);
                    phase_next               = PH_HALTED;
                    state_next               = S_OUT;
                end
                else if (top_is_end)
                begin
                    out_next.status      = ST_ACCEPTED;
                    out_next.stack_level = 7'(sp_reg);
                    phase_next           = PH_HALTED;
                    state_next           = S_OUT;
                end
                else if (steps_reg >= CW'(STEP_LIMIT))
                begin
                    out_next.status          = ST_OVERFLOW;
                    out_next.expected_symbol = top_sym;
                    out_next.stack_level     = 7'(sp_reg);
                    phase_next               = PH_HALTED;
                    state_next               = S_OUT;
                end
                else if (top_rdata[5])
                begin
                    // nonterminal: fetch entry length
                    idx_next   = EW'(32'(nt[4:0]) * NUM_TERMINALS + 32'(tok_reg));
                    steps_next = steps_reg + 1'b1;
                    if (32'(nt) >= 32'(ntcount_reg) || 32'(nt) >= NUM_NONTERMINALS)
                    begin
                        out_next.status          = ST_NO_ENTRY;
                        out_next.expected_symbol = top_sym;
                        out_next.stack_level     = 7'(sp_reg);
                        phase_next               = PH_HALTED;
                        state_next               = S_OUT;
                    end
                end
                else
                begin
                    steps_next = steps_reg + 1'b1;
                    if (top_rdata[4:0] == eps_reg)
                    begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = S_READ;
                    end
                    else if (top_rdata[4:0] == tok_reg)
                    begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        out_next.status          = ST_MISMATCH;
                        out_next.expected_symbol = top_sym;
                        out_next.stack_level     = 7'(sp_reg);
                        phase_next               = PH_HALTED;
                        state_next               = S_OUT;
                    end
                end
            end
            S_EVAL:
            begin
                // length available: check and start pushing
                if (len_rdata == '0)
                begin
                    out_next.status          = ST_NO_ENTRY;
                    out_next.expected_symbol = top_sym;
                    out_next.stack_level     = 7'(sp_reg);
                    phase_next               = PH_HALTED;
                    state_next               = S_OUT;
                end
                else if (32'(sp_reg) - 1 + 32'(len_rdata) > STACK_DEPTH)
                begin
                    out_next.status          = ST_OVERFLOW;
                    out_next.expected_symbol = top_sym;
                    out_next.stack_level     = 7'(sp_reg);
                    phase_next               = PH_HALTED;
                    state_next               = S_OUT;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    k_next     = len_rdata;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // one symbol per cycle; k_reg==0 marks the begin item's push
                if (k_reg == '0)
                begin
                    st_we                = 1'b1;
                    st_waddr             = AW'(1);
                    st_wdata             = 7'd32;
                    sp_next              = PW'(2);
                    out_next.stack_level = 7'd2;
                    state_next           = S_OUT;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_waddr = AW'(sp_reg);
                    st_wdata = {1'b0, sym_rdata};
                    sp_next  = sp_reg + 1'b1;
                    k_next   = k_reg - 1'b1;
                    if (k_reg == LW'(1))
                        state_next = S_READ;
                end
            end
            S_DONE:
            begin
                // new top read is back: accept when the end marker surfaces
                out_next.stack_level = 7'(sp_reg);
                if (top_is_end)
                begin
                    out_next.status = ST_ACCEPTED;
                    phase_next      = PH_HALTED;
                end
                else
                    out_next.status = ST_CONSUMED;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            sp_reg        <= '0;
            steps_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sp_reg        <= sp_next;
            steps_reg     <= steps_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

endmodule

// ===== tb/sv/ll1_predictive_parser_test.sv =====
// ---------------------------------------------------------------------------
// ll1_predictive_parser_test: self-checking bench of the LL(1) parser
// Loads grammars, runs begin/token sessions under random stalls on both
// channels and checks each result against a built-in table-driven parser.
// ---------------------------------------------------------------------------
module ll1_predictive_parser_test
    import ll1p_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumT       = DefNumTerminals;
    localparam int NumNt      = DefNumNonterminals;
    localparam int ProdLen    = DefMaxProdLength;
    localparam int Depth      = DefStackDepth;
    localparam int ExpandCap  = Depth * (NumNt + 2);
    localparam int CycleLimit = 20000000;

    typedef enum int {P_IDLE, P_RUN, P_HALT} parse_phase_e;

    // Shadow parser: tracks table, stack and registers, queues predicted results
    class parse_scoreboard;
        bit [3:0]     ent_len[NumT * NumNt];
        bit [5:0]     prod[NumT * NumNt * ProdLen];
        bit [7:0]     loaded_slots[NumT * NumNt];
        bit [6:0]     stk[Depth];
        int           sp;
        parse_phase_e phase;
        int           tcount;
        int           ntcount;
        int           eps;
        out_item_t    pending[$];
        int           errors;

        function new();
            foreach (ent_len[i]) ent_len[i] = '0;
            foreach (loaded_slots[i]) loaded_slots[i] = '0;
            sp = 0;
            phase = P_IDLE;
            tcount = 32;
            ntcount = 32;
            eps = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, int val);
            case (idx)
                CFG_TERM_COUNT: tcount = val & 63;
                CFG_NT_COUNT:   ntcount = val & 63;
                CFG_EPSILON:    eps = val & 31;
                default: ;
            endcase
        endfunction

        function bit [6:0] top_sym();
            if (sp == 0) return END_MARK;
            return stk[sp - 1];
        endfunction

        // Run one token to consumption, acceptance or error
        function void run_token(int tok, output logic [2:0] st, output logic [6:0] es);
            int       steps;
            int       nt;
            int       e;
            int       n;
            bit [6:0] top;
            steps = 0;
            es = '0;
            if (tok >= tcount) begin
                es = top_sym();
                phase = P_HALT;
                st = ST_INVALID;
                return;
            end
            forever begin
                top = top_sym();
                if (top == END_MARK) begin
                    phase = P_HALT;
                    st = ST_ACCEPTED;
                    return;
                end
                if (steps >= ExpandCap) begin
                    es = top;
                    phase = P_HALT;
                    st = ST_OVERFLOW;
                    return;
                end
                steps++;
                if (top >= 32) begin
                    nt = top - 32;
                    e = nt * NumT + tok;
                    n = (nt >= ntcount) ? 0 : ent_len[e];
                    if (n == 0) begin
                        es = top;
                        phase = P_HALT;
                        st = ST_NO_ENTRY;
                        return;
                    end
                    if (sp - 1 + n > Depth) begin
                        es = top;
                        phase = P_HALT;
                        st = ST_OVERFLOW;
                        return;
                    end
                    sp--;
                    for (int k = n; k > 0; k--) begin
                        stk[sp] = {1'b0, prod[e * ProdLen + k - 1]};
                        sp++;
                    end
                end else if (top == eps) begin
                    sp--;
                end else if (top == tok) begin
                    sp--;
                    if (top_sym() == END_MARK) begin
                        phase = P_HALT;
                        st = ST_ACCEPTED;
                    end else begin
                        st = ST_CONSUMED;
                    end
                    return;
                end else begin
                    es = top;
                    phase = P_HALT;
                    st = ST_MISMATCH;
                    return;
                end
            end
        endfunction

        // Apply an accepted item and queue the result it must produce
        function void note_input(in_item_t it);
            out_item_t r;
            int        e;
            int        l;
            e = it.nonterminal_index * NumT + it.terminal_index;
            r = '0;
            case (it.func)
                FUNC_LOAD_SYM: begin
                    prod[e * ProdLen + it.slot] = it.symbol_code;
                    loaded_slots[e][it.slot] = 1'b1;
                end
                FUNC_LOAD_LEN: begin
                    l = it.entry_length;
                    if (l > ProdLen) l = ProdLen;
                    ent_len[e] = l[3:0];
                end
                FUNC_BEGIN: begin
                    stk[0] = END_MARK;
                    stk[1] = 7'd32;
                    sp = 2;
                    phase = P_RUN;
                end
                default: begin
                    if (phase != P_RUN) r.status = ST_NOT_PARSE;
                    else run_token(it.terminal_index, r.status, r.expected_symbol);
                end
            endcase
            r.stack_level = sp[6:0];
            pending = {pending, r};
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: status %0d sym %0d level %0d",
                         $time, got.status, got.expected_symbol, got.stack_level);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.expected_symbol !== want.expected_symbol) begin
                errors++;
                $display("%0t: expected_symbol expected %0d actual %0d",
                         $time, want.expected_symbol, got.expected_symbol);
            end
            if (got.stack_level !== want.stack_level) begin
                errors++;
                $display("%0t: stack_level expected %0d actual %0d",
                         $time, want.stack_level, got.stack_level);
            end
        endfunction

        // Pick a token that the current stack top can take
        function int likely_token();
            int       i;
            int       nt;
            int       opts[$];
            bit [6:0] s;
            i = sp - 1;
            while (i >= 0 && stk[i] < 32 && stk[i] == eps) i--;
            if (i < 0) return $urandom_range(0, tcount - 1);
            s = stk[i];
            if (s < 32) return s;
            if (s == END_MARK) return $urandom_range(0, tcount - 1);
            nt = s - 32;
            for (int t = 0; t < tcount && t < NumT; t++)
                if (ent_len[nt * NumT + t] != 0) opts = {opts, t};
            if (opts.size() == 0) return $urandom_range(0, tcount - 1);
            return opts[$urandom_range(0, opts.size() - 1)];
        endfunction

        // Number of leading slots of an entry that have been loaded
        function int loaded_prefix(int e);
            int p;
            p = 0;
            while (p < ProdLen && loaded_slots[e][p]) p++;
            return p;
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_TERM_COUNT;
    logic [5:0] cfg_data = '0;

    parse_scoreboard sb = new();
    bit              calm = 1'b0;
    bit              hold_req = 1'b0;
    int              cycles = 0;
    int              items_sent = 0;

    ll1_predictive_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Take results, stalling at random or for one long hold
    initial
    begin : result_side
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_result(out_data);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (calm || $urandom_range(0, 99) < 65)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t make_item(logic [1:0] f, int nt, int t, int slot,
                                           int code, int len);
        in_item_t it;
        it.func = f;
        it.nonterminal_index = nt[4:0];
        it.terminal_index = t[4:0];
        it.slot = slot[2:0];
        it.symbol_code = code[5:0];
        it.entry_length = len[3:0];
        return it;
    endfunction

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_item(in_item_t it);
        int gap;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[5:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_entry(int nt, int t, int len, bit [5:0] syms[$]);
        foreach (syms[k]) send_item(make_item(FUNC_LOAD_SYM, nt, t, k, syms[k], 0));
        send_item(make_item(FUNC_LOAD_LEN, nt, t, 0, 0, len));
    endtask

    task automatic begin_parse();
        send_item(make_item(FUNC_BEGIN, 0, 0, 0, 0, 0));
    endtask

    task automatic token(int t);
        send_item(make_item(FUNC_TOKEN, $urandom_range(0, 31), t,
                            $urandom_range(0, 7), $urandom_range(0, 63),
                            $urandom_range(0, 15)));
    endtask

    // Random grammar: terminals lead, nonterminals mostly point further down
    task automatic load_grammar();
        int          nt;
        int          t;
        int          len;
        int          r;
        bit [5:0]    syms[$];
        for (int n = 0; n < 8; n++)
        begin
            syms.delete();
            nt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                 : $urandom_range(0, (sb.ntcount > 32 ? 32 : sb.ntcount) - 1);
            t = $urandom_range(0, sb.tcount - 1);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
            begin
                r = $urandom_range(0, 9);
                if (k == 0 && r < 6) syms = {syms, 6'(t)};
                else if (r < 4) syms = {syms, 6'($urandom_range(0, sb.tcount - 1))};
                else if (r < 7 && nt < 31) syms = {syms, 6'(32 + $urandom_range(nt + 1, 31))};
                else if (r < 8) syms = {syms, 6'(sb.eps)};
                else syms = {syms, 6'($urandom_range(0, 63))};
            end
            if (len == ProdLen && $urandom_range(0, 1)) len = $urandom_range(9, 15);
            load_entry(nt, t, len, syms);
        end
    endtask

    // Any item; length loads never expose a slot that was not loaded
    task automatic send_noise();
        in_item_t it;
        int       e;
        int       p;
        it = make_item(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15));
        if (it.func == FUNC_LOAD_LEN)
        begin
            e = it.nonterminal_index * NumT + it.terminal_index;
            p = sb.loaded_prefix(e);
            if ((it.entry_length > ProdLen ? ProdLen : it.entry_length) > p)
                it.entry_length = p[3:0];
        end
        send_item(it);
    endtask

    initial
    begin : stimulus
        bit [5:0] q[$];
        int       cfgs[6][3];
        int       goal;
        int       n;
        cfgs = '{'{32, 32, 0}, '{1, 1, 31}, '{8, 4, 3}, '{32, 32, 31},
                 '{16, 32, 0}, '{32, 8, 5}};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (!in_ready) @(posedge clk);

        // Directed: idle token, consume, accept, epsilon, errors, overflow
        write_reg(CFG_TERM_COUNT, 32);
        write_reg(CFG_NT_COUNT, 32);
        write_reg(CFG_EPSILON, 0);
        token(1);
        q = '{6'd1, 6'd33};                       load_entry(0, 1, 2, q);
        q = '{6'd2};                              load_entry(1, 2, 1, q);
        q = '{6'd0};                              load_entry(1, 3, 1, q);
        q = '{6'd7};                              load_entry(0, 6, 1, q);
        q = '{6'd33};                             load_entry(0, 7, 1, q);
        q = '{6'd33, 6'd33};                      load_entry(1, 7, 2, q);
        q = '{6'd34};                             load_entry(0, 8, 1, q);
        load_entry(2, 8, 1, q);
        q = '{6'd4, 6'd4, 6'd4, 6'd4, 6'd4, 6'd4, 6'd4, 6'd63};
        load_entry(0, 4, 15, q);
        begin_parse(); token(1); token(2); token(2);
        begin_parse(); token(1); token(3);
        begin_parse(); token(5);
        begin_parse(); token(6);
        begin_parse(); token(7);
        begin_parse(); token(8);
        begin_parse(); token(4); token(4); token(31);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_reg(CFG_TERM_COUNT, cfgs[ph][0]);
            write_reg(CFG_NT_COUNT, cfgs[ph][1]);
            write_reg(CFG_EPSILON, cfgs[ph][2]);
            calm = (ph == 3);
            if (ph == 1) hold_req = 1'b1;
            load_grammar();
            goal = items_sent + 20;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_noise();
                end
                else
                begin
                    begin_parse();
                    n = 0;
                    while (sb.phase == P_RUN && n < 25)
                    begin
                        if ($urandom_range(0, 19) == 0) send_noise();
                        else if ($urandom_range(0, 9) < 8) token(sb.likely_token());
                        else token($urandom_range(0, 31));
                        n++;
                    end
                    if ($urandom_range(0, 3) == 0) token($urandom_range(0, 31));
                end
            end
        end
        calm = 1'b0;

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== ll1_predictive_parser.f =====
src/ll1p_pkg.sv
src/ll1p_table.sv
src/ll1_predictive_parser.sv
tb/sv/ll1_predictive_parser_test.sv
